### rtl/gesp_pkg.sv
// ----------------------------------------------------------------------------
// gesp_pkg
// Shared types and constants for the greedy edge stream partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gesp_pkg;

  // fixed field widths
  localparam int VID_W     = 11;
  localparam int GRP_OUT_W = 2;
  localparam int OUTC_W    = 2;
  localparam int NG_W      = 3;
  localparam int QUOTA_W   = 24;
  localparam int CFG_IDX_W = 1;

  // parameter defaults
  localparam int DEF_MAX_GROUPS   = 4;
  localparam int DEF_MAX_VERTICES = 2048;
  localparam int DEF_LOAD_WIDTH   = 24;
  localparam int QUEUE_DEPTH      = 2;

  // reset value of the group count register
  localparam logic [NG_W-1:0] RST_NUM_GROUPS = 3'd4;

  // fixed-point shift for the vertex wrap reciprocal
  localparam int RECIP_SHIFT = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_GROUPS = 1'b0,
    CFG_EDGE_QUOTA = 1'b1
  } gesp_cfg_idx_t;

  typedef enum logic [OUTC_W-1:0] {
    OUT_SKIP     = 2'd0,
    OUT_DEST_NEW = 2'd1,
    OUT_SRC_NEW  = 2'd2,
    OUT_BOTH_NEW = 2'd3
  } gesp_outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WRITE2
  } gesp_state_t;

  typedef struct packed {
    logic [VID_W-1:0] src_vertex;
    logic [VID_W-1:0] dest_vertex;
  } gesp_in_t;

  typedef struct packed {
    logic [GRP_OUT_W-1:0] src_group;
    logic [GRP_OUT_W-1:0] dest_group;
    logic [OUTC_W-1:0]    outcome;
  } gesp_out_t;

endpackage

`default_nettype wire

### rtl/gesp_front.sv
// ----------------------------------------------------------------------------
// gesp_front
// Input stage: takes edge beats, wraps vertex ids into table range, flags
// self loops and pushes the classified edge into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gesp_front #(
  parameter int MAX_VERTICES = gesp_pkg::DEF_MAX_VERTICES,
  parameter int AW           = $clog2(gesp_pkg::DEF_MAX_VERTICES)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gesp_pkg::gesp_in_t  in_data,
  input  wire logic                clearing,
  input  wire logic                q_full,
  output logic                     q_push,
  output logic [2*AW:0]            q_entry
);
  import gesp_pkg::*;

  localparam int PW = VID_W + RECIP_SHIFT;
  localparam logic [PW-1:0] RECIP = PW'((1 << RECIP_SHIFT) / MAX_VERTICES);

  logic             a_valid;
  logic [VID_W-1:0] a_src;
  logic [VID_W-1:0] a_dest;
  logic [VID_W-1:0] a_qs;
  logic [VID_W-1:0] a_qd;
  logic [PW-1:0]    prod_s;
  logic [PW-1:0]    prod_d;
  logic             take;
  logic [AW-1:0]    ws;
  logic [AW-1:0]    wd;

  // remainder from an estimated quotient that is at most one low
  function automatic logic [AW-1:0] wrap(input logic [VID_W-1:0] v,
                                         input logic [VID_W-1:0] q);
    logic [31:0] r;
    r = 32'(v) - 32'(q) * 32'(MAX_VERTICES);
    if (r >= 32'(MAX_VERTICES)) r = r - 32'(MAX_VERTICES);
    return r[AW-1:0];
  endfunction

  assign prod_s = PW'(in_data.src_vertex) * RECIP;
  assign prod_d = PW'(in_data.dest_vertex) * RECIP;

  assign in_stall = clearing || (a_valid && q_full);
  assign take     = in_valid && !in_stall;
  assign q_push   = a_valid && !q_full;

  assign ws      = wrap(a_src, a_qs);
  assign wd      = wrap(a_dest, a_qd);
  assign q_entry = {(ws == wd), wd, ws};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (q_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_src  <= in_data.src_vertex;
      a_dest <= in_data.dest_vertex;
      a_qs   <= prod_s[RECIP_SHIFT +: VID_W];
      a_qd   <= prod_d[RECIP_SHIFT +: VID_W];
    end
  end

endmodule

`default_nettype wire

### rtl/gesp_fifo.sv
// ----------------------------------------------------------------------------
// gesp_fifo
// Short queue between the input stage and the placement engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gesp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gesp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  full,
  output logic                  empty
);
  import gesp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/gesp_back.sv
// ----------------------------------------------------------------------------
// gesp_back
// Placement engine: vertex table lookups, group choice, table writes,
// group load counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gesp_back #(
  parameter int MAX_GROUPS   = gesp_pkg::DEF_MAX_GROUPS,
  parameter int MAX_VERTICES = gesp_pkg::DEF_MAX_VERTICES,
  parameter int LOAD_WIDTH   = gesp_pkg::DEF_LOAD_WIDTH,
  parameter int AW           = $clog2(gesp_pkg::DEF_MAX_VERTICES)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire logic [2*AW:0]                 q_entry,
  output logic                               q_pop,
  input  wire logic [MAX_GROUPS-1:0]         group_mask,
  input  wire logic [gesp_pkg::QUOTA_W-1:0]  edge_quota,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output gesp_pkg::gesp_out_t                out_data,
  output logic                               clearing
);
  import gesp_pkg::*;

  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int LVL = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 0;
  localparam int P   = 1 << LVL;
  localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

  gesp_state_t state, state_next;

  // vertex table: placed mark above the group
  logic [GW:0]           vmem [MAX_VERTICES];
  logic [GW:0]           rd_s;
  logic [GW:0]           rd_d;
  logic                  mem_re;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [GW:0]           mem_wdata;
  logic [AW-1:0]         clr_cnt;

  logic [AW-1:0]         cur_s;
  logic [AW-1:0]         cur_d;
  logic                  cur_same;
  logic [GW-1:0]         best;
  logic [GW-1:0]         best_comb;

  logic [LOAD_WIDTH-1:0] load [MAX_GROUPS];
  logic                  inc_en;
  logic [GW-1:0]         inc_grp;

  logic                  out_free;
  logic                  fire;
  gesp_out_t             res;

  logic                  sp;
  logic                  dp;
  logic [GW-1:0]         ps;
  logic [GW-1:0]         pd;
  logic [GW-1:0]         join_sel;
  logic [GW-1:0]         join_grp;

  // least-loaded tree, heap order, leaves at P-1 .. 2P-2
  logic [LOAD_WIDTH-1:0] t_load [2*P-1];
  logic                  t_ok   [2*P-1];
  logic [GW-1:0]         t_idx  [2*P-1];

  always_comb begin
    for (int j = 0; j < P; j++) begin
      if (j < MAX_GROUPS) begin
        t_load[P-1+j] = load[j];
        t_ok[P-1+j]   = group_mask[j];
      end else begin
        t_load[P-1+j] = '0;
        t_ok[P-1+j]   = 1'b0;
      end
      t_idx[P-1+j] = GW'(j);
    end
    // left child always holds the lower indexes, so ties stay left
    for (int i = P - 2; i >= 0; i--) begin
      if (!t_ok[2*i+1] || (t_ok[2*i+2] && (t_load[2*i+2] < t_load[2*i+1]))) begin
        t_load[i] = t_load[2*i+2];
        t_ok[i]   = t_ok[2*i+2];
        t_idx[i]  = t_idx[2*i+2];
      end else begin
        t_load[i] = t_load[2*i+1];
        t_ok[i]   = t_ok[2*i+1];
        t_idx[i]  = t_idx[2*i+1];
      end
    end
    best_comb = t_idx[0];
  end

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || !out_stall;

  assign sp       = rd_s[GW];
  assign dp       = rd_d[GW];
  assign ps       = rd_s[GW-1:0];
  assign pd       = rd_d[GW-1:0];
  assign join_sel = sp ? ps : pd;
  assign join_grp = (32'(load[join_sel]) < 32'(edge_quota)) ? join_sel : best;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(MAX_VERTICES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = (!sp && !dp && !cur_same) ? ST_WRITE2 : ST_IDLE;
        end
      end
      ST_WRITE2: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_s;
    mem_wdata = {1'b1, best};
    inc_en    = 1'b0;
    inc_grp   = best;
    fire      = 1'b0;
    res.src_group  = GRP_OUT_W'(ps);
    res.dest_group = GRP_OUT_W'(pd);
    res.outcome    = OUT_SKIP;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        q_pop  = !q_empty;
        mem_re = !q_empty;
      end
      ST_EXEC: begin
        fire = out_free;
        if (sp && dp) begin
          res.outcome = OUT_SKIP;
        end else if (sp) begin
          res.outcome    = OUT_DEST_NEW;
          res.dest_group = GRP_OUT_W'(join_grp);
          mem_we         = out_free;
          mem_waddr      = cur_d;
          mem_wdata      = {1'b1, join_grp};
          inc_en         = out_free;
          inc_grp        = ps;
        end else if (dp) begin
          res.outcome   = OUT_SRC_NEW;
          res.src_group = GRP_OUT_W'(join_grp);
          mem_we        = out_free;
          mem_waddr     = cur_s;
          mem_wdata     = {1'b1, join_grp};
          inc_en        = out_free;
          inc_grp       = join_grp;
        end else begin
          res.outcome    = OUT_BOTH_NEW;
          res.src_group  = GRP_OUT_W'(best);
          res.dest_group = GRP_OUT_W'(best);
          mem_we         = out_free;
          mem_waddr      = cur_s;
          mem_wdata      = {1'b1, best};
          inc_en         = out_free;
          inc_grp        = best;
        end
      end
      ST_WRITE2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_d;
        mem_wdata = {1'b1, best};
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_s <= vmem[q_entry[AW-1:0]];
      rd_d <= vmem[q_entry[2*AW-1:AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // edge context, captured at pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_s    <= q_entry[AW-1:0];
      cur_d    <= q_entry[2*AW-1:AW];
      cur_same <= q_entry[2*AW];
      best     <= best_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < MAX_GROUPS; g++) load[g] <= '0;
    end else if (inc_en && (load[inc_grp] != LOAD_MAX)) begin
      load[inc_grp] <= load[inc_grp] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= res;
  end

endmodule

`default_nettype wire

### rtl/greedy_edge_stream_partitioner.sv
// ----------------------------------------------------------------------------
// greedy_edge_stream_partitioner
// Streams sorted graph edges and assigns each new vertex to a partition,
// joining a placed neighbor's group while under quota, else the least
// loaded group.
//
//   channel  dir  handshake           beat
//   in       in   in_valid/in_stall   gesp_in_t  (src, dest vertex)
//   out      out  out_valid/out_stall gesp_out_t (groups, outcome)
//   cfg      in   cfg_valid/cfg_ready index + 24-bit data
//
// The placement engine takes an edge through a table read state, then a
// decide and write state, plus a second write state when both endpoints are
// new and distinct, since the vertex table has one write port.
// After reset the vertex table is cleared one entry a cycle, with in_stall
// high throughout; cfg writes are taken meanwhile.
// The result register and a two-entry queue let input and output stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_edge_stream_partitioner #(
  parameter int MAX_GROUPS   = gesp_pkg::DEF_MAX_GROUPS,
  parameter int MAX_VERTICES = gesp_pkg::DEF_MAX_VERTICES,
  parameter int LOAD_WIDTH   = gesp_pkg::DEF_LOAD_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire gesp_pkg::gesp_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output gesp_pkg::gesp_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gesp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gesp_pkg::QUOTA_W-1:0]   cfg_data
);
  import gesp_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = 2 * AW + 1;

  logic [MAX_GROUPS-1:0] group_mask;
  logic [MAX_GROUPS-1:0] group_mask_next;
  logic [MAX_GROUPS-1:0] group_mask_rst;
  logic [QUOTA_W-1:0]    edge_quota;
  logic                  cfg_we;

  logic                  clearing;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [EW-1:0]         q_din;
  logic [EW-1:0]         q_dout;

  function automatic logic [MAX_GROUPS-1:0] mask_of(input logic [NG_W-1:0] n);
    int unsigned ne;
    logic [MAX_GROUPS-1:0] m;
    ne = (n == '0) ? 1 : 32'(n);
    if (ne > MAX_GROUPS) ne = MAX_GROUPS;
    for (int i = 0; i < MAX_GROUPS; i++) m[i] = (i < ne);
    return m;
  endfunction

  assign cfg_ready       = 1'b1;
  assign cfg_we          = cfg_valid && cfg_ready;
  assign group_mask_next = mask_of(cfg_data[NG_W-1:0]);
  assign group_mask_rst  = mask_of(RST_NUM_GROUPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_mask <= group_mask_rst;
      edge_quota <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_GROUPS: group_mask <= group_mask_next;
        CFG_EDGE_QUOTA: edge_quota <= cfg_data;
        default: ;
      endcase
    end
  end

  gesp_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_din)
  );

  gesp_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  gesp_back #(
    .MAX_GROUPS   (MAX_GROUPS),
    .MAX_VERTICES (MAX_VERTICES),
    .LOAD_WIDTH   (LOAD_WIDTH),
    .AW           (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_entry    (q_dout),
    .q_pop      (q_pop),
    .group_mask (group_mask),
    .edge_quota (edge_quota),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .clearing   (clearing)
  );

  // no result can appear before the table clear is done
  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result valid during table clear");

  // both-new edges land in one group
  a_both_new_same_group: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.outcome == OUT_BOTH_NEW))
      |-> (out_data.src_group == out_data.dest_group))
    else $error("both-new edge split across groups");

  // the input stage never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  // an accepted edge cannot be taken during the table clear
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (clearing && in_valid) |-> in_stall)
    else $error("edge accepted during table clear");

endmodule

`default_nettype wire

### dv/greedy_edge_stream_partitioner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_edge_stream_partitioner_tb
// Streams edges into the partitioner under several group count and quota
// settings, predicts each vertex placement and group load update, and checks
// every output beat in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module greedy_edge_stream_partitioner_tb;
  import gesp_pkg::*;

  localparam int GROUPS          = DEF_MAX_GROUPS;
  localparam int VERTICES        = DEF_MAX_VERTICES;
  localparam int QUIET_LIMIT     = 10000;
  localparam int RANDOM_PHASES   = 8;
  localparam int EDGES_PER_PHASE = 116;
  localparam int RECENT_DEPTH    = 48;
  localparam logic [DEF_LOAD_WIDTH-1:0] LOAD_SAT = '1;

  typedef logic [GRP_OUT_W-1:0] grp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  gesp_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  gesp_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUOTA_W-1:0]   cfg_data = '0;

  greedy_edge_stream_partitioner u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the partition tables and registers
  grp_t                      part_of [VERTICES] = '{default: '0};
  bit                        placed  [VERTICES];
  logic [DEF_LOAD_WIDTH-1:0] load_of [GROUPS]   = '{default: '0};
  logic [NG_W-1:0]           cur_groups = RST_NUM_GROUPS;
  logic [QUOTA_W-1:0]        cur_quota  = '0;

  gesp_in_t  edges_to_send[$];
  gesp_out_t predicted_placements[$];
  int        recent_vertices[$];

  int  edges_queued     = 0;
  int  results_checked  = 0;
  int  settings_applied = 0;
  int  errors           = 0;
  int  quiet_cycles     = 0;
  int  outcome_seen [4] = '{default: 0};
  int  in_gap           = 0;
  int  out_hold         = 0;
  bit  in_calm          = 1'b0;
  bit  out_calm         = 1'b0;

  function automatic grp_t lightest_group();
    int   n;
    grp_t best;
    n = (cur_groups == 0) ? 1 : (cur_groups > GROUPS) ? GROUPS : int'(cur_groups);
    best = '0;
    for (int i = 1; i < n; i++)
      if (load_of[i] < load_of[best]) best = grp_t'(i);
    return best;
  endfunction

  // a placed neighbor's group is kept even if it is above the current count
  function automatic grp_t join_group(input grp_t g);
    if (load_of[g] < cur_quota) return g;
    return lightest_group();
  endfunction

  function automatic gesp_out_t place_edge(input gesp_in_t e);
    gesp_out_t        r;
    logic [VID_W-1:0] s;
    logic [VID_W-1:0] d;
    grp_t             g;
    s = e.src_vertex;
    d = e.dest_vertex;
    if (placed[s] && placed[d]) begin
      r.outcome = OUT_SKIP;
    end else begin
      if (placed[s]) begin
        part_of[d] = join_group(part_of[s]);
        placed[d]  = 1'b1;
        r.outcome  = OUT_DEST_NEW;
      end else if (placed[d]) begin
        part_of[s] = join_group(part_of[d]);
        placed[s]  = 1'b1;
        r.outcome  = OUT_SRC_NEW;
      end else begin
        g          = lightest_group();
        part_of[s] = g;
        part_of[d] = g;
        placed[s]  = 1'b1;
        placed[d]  = 1'b1;
        r.outcome  = OUT_BOTH_NEW;
      end
      g = part_of[s];
      if (load_of[g] != LOAD_SAT) load_of[g] = load_of[g] + 1'b1;
    end
    r.src_group  = part_of[s];
    r.dest_group = part_of[d];
    return r;
  endfunction

  // mostly short gaps, a few long ones; calm stretches have none
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int pick_vertex();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && recent_vertices.size() != 0)
      return recent_vertices[$urandom_range(0, recent_vertices.size() - 1)];
    if (r < 50) return r[0] ? VERTICES - 1 : 0;
    return $urandom_range(0, VERTICES - 1);
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  task automatic queue_edge(input int s, input int d);
    gesp_in_t e;
    e.src_vertex  = VID_W'(s);
    e.dest_vertex = VID_W'(d);
    edges_to_send = {edges_to_send, e};
    edges_queued++;
  endtask

  // reuse of recent vertices makes known endpoints and skipped edges common
  task automatic queue_random_edge();
    int s;
    int d;
    s = pick_vertex();
    d = ($urandom_range(0, 19) == 0) ? s : pick_vertex();
    queue_edge(s, d);
    recent_vertices = {recent_vertices, s, d};
    while (recent_vertices.size() > RECENT_DEPTH) void'(recent_vertices.pop_front());
  endtask

  task automatic wait_drained();
    while (results_checked != edges_queued) @(posedge clk);
  endtask

  // valid stays high across both register beats
  task automatic apply_setting(input logic [QUOTA_W-1:0] groups,
                               input logic [QUOTA_W-1:0] quota);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_GROUPS;
    cfg_data  <= groups;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_groups = groups[NG_W-1:0];
    cfg_index <= CFG_EDGE_QUOTA;
    cfg_data  <= quota;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_quota = quota;
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // edge driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predicted_placements = {predicted_placements, place_edge(in_data)};
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (edges_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= edges_to_send.pop_front();
          in_gap = idle_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // placement monitor
  always @(posedge clk) begin : check_placement
    gesp_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_placements.size() == 0) begin
          flag_error($sformatf("unexpected beat src_group=%0d dest_group=%0d outcome=%0d",
                               out_data.src_group, out_data.dest_group, out_data.outcome));
        end else begin
          want = predicted_placements.pop_front();
          results_checked++;
          outcome_seen[want.outcome]++;
          if (out_data.src_group !== want.src_group ||
              out_data.dest_group !== want.dest_group ||
              out_data.outcome !== want.outcome)
            flag_error($sformatf({"beat %0d: expected src_group=%0d dest_group=%0d ",
                                  "outcome=%0d, got %0d %0d %0d"},
                                 results_checked, want.src_group, want.dest_group,
                                 want.outcome, out_data.src_group, out_data.dest_group,
                                 out_data.outcome));
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        out_hold = idle_len(out_calm);
      end
    end
  end

  // watchdog: covers the table clear after reset plus the longest gaps
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  logic [QUOTA_W-1:0] phase_groups [RANDOM_PHASES] =
    '{24'd4, 24'd2, 24'd1, 24'd3, 24'd0, 24'hFFFFFF, 24'h000C02, 24'd4};
  logic [QUOTA_W-1:0] phase_quota  [RANDOM_PHASES] =
    '{24'd1000, 24'd5, 24'd0, 24'hFFFFFF, 24'd2, 24'd40, 24'hFFFFFF, 24'd20};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: four groups, zero quota, so joins never happen
    queue_edge(0, 2047);
    queue_edge(2047, 0);
    queue_edge(5, 5);
    queue_edge(5, 5);
    queue_edge(0, 6);
    queue_edge(7, 2047);
    queue_edge(8, 9);
    wait_drained();

    // small quota: joins until the hub's group fills, then least loaded
    apply_setting(24'd4, 24'd3);
    queue_edge(10, 11);
    queue_edge(10, 12);
    queue_edge(10, 13);
    queue_edge(10, 14);
    queue_edge(10, 15);
    queue_edge(16, 10);
    queue_edge(1365, 682);
    queue_edge(682, 1365);
    queue_edge(2047, 2047);
    wait_drained();

    // zero group count acts as one group
    apply_setting(24'd0, 24'd3);
    queue_edge(100, 101);
    queue_edge(100, 102);
    queue_edge(103, 100);
    wait_drained();

    // count above range acts as four, quota at its top
    apply_setting(24'd7, 24'hFFFFFF);
    queue_edge(200, 201);
    queue_edge(200, 202);
    queue_edge(203, 5);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      apply_setting(phase_groups[p], phase_quota[p]);
      repeat (EDGES_PER_PHASE) queue_random_edge();
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d edges across %0d register settings, %0d mismatches",
             edges_queued, settings_applied + 1, errors);
    $display("Outcomes checked: skipped %0d, dest new %0d, src new %0d, both new %0d",
             outcome_seen[OUT_SKIP], outcome_seen[OUT_DEST_NEW],
             outcome_seen[OUT_SRC_NEW], outcome_seen[OUT_BOTH_NEW]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gesp_pkg.sv
rtl/gesp_front.sv
rtl/gesp_fifo.sv
rtl/gesp_back.sv
rtl/greedy_edge_stream_partitioner.sv
dv/greedy_edge_stream_partitioner_tb.sv
